FILE: hdl/nnfs_pkg.sv
// Package for the nearest-neighbor frame scaler: payload structs, status and
// command codes, register indexes and register reset values.
// No dependencies.
package nnfs_pkg;

  localparam int POS_W   = 13;
  localparam int SIZE_W  = 13;
  localparam int RATIO_W = 29;
  localparam int PIXEL_W = 24;
  localparam int FRAC_W  = 16;
  localparam int PROD_W  = POS_W + RATIO_W;
  localparam int REG_INDEX_W = 3;
  localparam int REG_DATA_W  = RATIO_W;

  typedef enum logic [REG_INDEX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_DEST_WIDTH    = 3'd2,
    REG_DEST_HEIGHT   = 3'd3,
    REG_RATIO_X       = 3'd4,
    REG_RATIO_Y       = 3'd5
  } reg_index_t;

  localparam logic [SIZE_W-1:0]  SOURCE_WIDTH_RESET  = 13'd640;
  localparam logic [SIZE_W-1:0]  SOURCE_HEIGHT_RESET = 13'd480;
  localparam logic [SIZE_W-1:0]  DEST_WIDTH_RESET    = 13'd1920;
  localparam logic [SIZE_W-1:0]  DEST_HEIGHT_RESET   = 13'd1080;
  localparam logic [RATIO_W-1:0] RATIO_X_RESET       = 29'd21845;
  localparam logic [RATIO_W-1:0] RATIO_Y_RESET       = 29'd29127;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  typedef enum logic [1:0] {
    ST_WRITE = 2'd0,
    ST_READ  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_ERROR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic              mode;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [PIXEL_W-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] pixel_out;
    status_t            status;
  } out_item_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [PIXEL_W-1:0] pixel;
  } cmd_t;

endpackage

FILE: hdl/nnfs_front.sv
// Front end of the frame scaler: configuration registers, coordinate scaling,
// range checks and frame index computation. Depends on nnfs_pkg.
module nnfs_front #(
  parameter int FRAME_PIXELS = 524288,
  parameter int COORD_BITS   = 13,
  parameter int ADDR_W       = 19
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               write_enable,
  input  logic [nnfs_pkg::REG_INDEX_W-1:0]   reg_index,
  input  logic [nnfs_pkg::REG_DATA_W-1:0]    write_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  nnfs_pkg::in_item_t                 in_item,
  output logic                               push_valid,
  output nnfs_pkg::cmd_t                     push_cmd,
  output logic [ADDR_W-1:0]                  push_addr,
  input  logic                               queue_full
);

  localparam int POS_W  = nnfs_pkg::POS_W;
  localparam int PROD_W = nnfs_pkg::PROD_W;
  localparam int SRC_W  = PROD_W - nnfs_pkg::FRAC_W;
  localparam int IDX_W  = 2 * POS_W + 1;
  localparam int USED_BITS = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam logic [POS_W-1:0] POS_MASK = {POS_W{1'b1}} >> (POS_W - USED_BITS);
  localparam logic [IDX_W-1:0] FRAME_LIMIT = IDX_W'(FRAME_PIXELS);

  logic [nnfs_pkg::SIZE_W-1:0]  source_width, source_height, dest_width, dest_height;
  logic [nnfs_pkg::RATIO_W-1:0] ratio_x, ratio_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= nnfs_pkg::SOURCE_WIDTH_RESET;
      source_height <= nnfs_pkg::SOURCE_HEIGHT_RESET;
      dest_width    <= nnfs_pkg::DEST_WIDTH_RESET;
      dest_height   <= nnfs_pkg::DEST_HEIGHT_RESET;
      ratio_x       <= nnfs_pkg::RATIO_X_RESET;
      ratio_y       <= nnfs_pkg::RATIO_Y_RESET;
    end else if (write_enable) begin
      unique case (reg_index)
        nnfs_pkg::REG_SOURCE_WIDTH:  source_width  <= write_data[nnfs_pkg::SIZE_W-1:0];
        nnfs_pkg::REG_SOURCE_HEIGHT: source_height <= write_data[nnfs_pkg::SIZE_W-1:0];
        nnfs_pkg::REG_DEST_WIDTH:    dest_width    <= write_data[nnfs_pkg::SIZE_W-1:0];
        nnfs_pkg::REG_DEST_HEIGHT:   dest_height   <= write_data[nnfs_pkg::SIZE_W-1:0];
        nnfs_pkg::REG_RATIO_X:       ratio_x       <= write_data;
        nnfs_pkg::REG_RATIO_Y:       ratio_y       <= write_data;
        default: ;
      endcase
    end
  end

  // Stage 1: masked coordinates, scaled products, destination bounds.
  logic                        s1_valid;
  logic                        s1_mode;
  logic [POS_W-1:0]            s1_x, s1_y;
  logic [nnfs_pkg::PIXEL_W-1:0] s1_pixel;
  logic [PROD_W-1:0]           s1_prod_x, s1_prod_y;
  logic                        s1_dest_ok;

  // Stage 2: command kind and frame index.
  logic                        s2_valid;
  logic                        s2_mode;
  logic                        s2_coord_ok;
  logic [IDX_W-1:0]            s2_idx;
  logic [nnfs_pkg::PIXEL_W-1:0] s2_pixel;

  logic             advance;
  logic [POS_W-1:0] x_in, y_in;
  logic [PROD_W-1:0] prod_x, prod_y;
  logic [SRC_W-1:0] cx, cy;
  logic             coord_ok;
  logic [2*POS_W-1:0] row_base;
  logic [IDX_W-1:0] idx;

  // Stall the whole front only when stage 2 holds an item the queue cannot take.
  assign advance  = !s2_valid || !queue_full;
  assign in_ready = advance;

  assign x_in   = in_item.pos_x & POS_MASK;
  assign y_in   = in_item.pos_y & POS_MASK;
  assign prod_x = x_in * ratio_x;
  assign prod_y = y_in * ratio_y;

  always_comb begin
    if (s1_mode == nnfs_pkg::MODE_READ) begin
      cx = s1_prod_x[PROD_W-1:nnfs_pkg::FRAC_W];
      cy = s1_prod_y[PROD_W-1:nnfs_pkg::FRAC_W];
    end else begin
      cx = SRC_W'(s1_x);
      cy = SRC_W'(s1_y);
    end
  end

  assign coord_ok = (cx < SRC_W'(source_width)) && (cy < SRC_W'(source_height)) &&
                    ((s1_mode == nnfs_pkg::MODE_WRITE) || s1_dest_ok);
  assign row_base = cy[POS_W-1:0] * source_width;
  assign idx      = IDX_W'(row_base) + IDX_W'(cx[POS_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mode    <= in_item.mode;
      s1_x       <= x_in;
      s1_y       <= y_in;
      s1_pixel   <= in_item.pixel_in;
      s1_prod_x  <= prod_x;
      s1_prod_y  <= prod_y;
      s1_dest_ok <= (x_in < dest_width) && (y_in < dest_height);
      s2_mode     <= s1_mode;
      s2_coord_ok <= coord_ok;
      s2_idx      <= idx;
      s2_pixel    <= s1_pixel;
    end
  end

  // Classify: anything outside the frame or past the store becomes an error.
  always_comb begin
    push_cmd.pixel = s2_pixel;
    if (!s2_coord_ok || (s2_idx >= FRAME_LIMIT)) begin
      push_cmd.kind = nnfs_pkg::CMD_ERROR;
    end else if (s2_mode == nnfs_pkg::MODE_READ) begin
      push_cmd.kind = nnfs_pkg::CMD_READ;
    end else begin
      push_cmd.kind = nnfs_pkg::CMD_WRITE;
    end
  end

  assign push_valid = s2_valid;
  assign push_addr  = s2_idx[ADDR_W-1:0];

endmodule

FILE: hdl/nnfs_queue.sv
// Small register queue between the scaler front and back ends.
// Depends on nnfs_pkg for the command type.
module nnfs_queue #(
  parameter int DEPTH  = 4,
  parameter int ADDR_W = 19
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  input  nnfs_pkg::cmd_t      push_cmd,
  input  logic [ADDR_W-1:0]   push_addr,
  output logic                full,
  input  logic                pop,
  output nnfs_pkg::cmd_t      pop_cmd,
  output logic [ADDR_W-1:0]   pop_addr,
  output logic                empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(DEPTH - 1);

  nnfs_pkg::cmd_t    cmd_slot [DEPTH];
  logic [ADDR_W-1:0] addr_slot [DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [CNT_W-1:0]  count;
  logic              do_push, do_pop;

  assign full    = (count == COUNT_MAX);
  assign empty   = (count == '0);
  assign do_push = push_valid && !full;
  assign do_pop  = pop && !empty;

  assign pop_cmd  = cmd_slot[rd_ptr];
  assign pop_addr = addr_slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      cmd_slot[wr_ptr]  <= push_cmd;
      addr_slot[wr_ptr] <= push_addr;
    end
  end

endmodule

FILE: hdl/nnfs_back.sv
// Back end of the frame scaler: frame memory access and the result register.
// Depends on nnfs_pkg.
module nnfs_back #(
  parameter int FRAME_PIXELS = 524288,
  parameter int ADDR_W       = 19
) (
  input  logic                 clk,
  input  logic                 rst,
  output logic                 pop,
  input  nnfs_pkg::cmd_t       pop_cmd,
  input  logic [ADDR_W-1:0]    pop_addr,
  input  logic                 empty,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nnfs_pkg::out_item_t  out_item
);

  logic [nnfs_pkg::PIXEL_W-1:0] frame_mem [FRAME_PIXELS];
  logic [nnfs_pkg::PIXEL_W-1:0] rdata;
  logic                         b1_valid;
  nnfs_pkg::cmd_kind_t          b1_kind;
  logic                         out_free, b_en;
  nnfs_pkg::out_item_t          result;

  assign out_free = !out_valid || out_ready;
  assign b_en     = !b1_valid || out_free;
  assign pop      = b_en && !empty;

  always_ff @(posedge clk) begin
    if (pop && (pop_cmd.kind == nnfs_pkg::CMD_WRITE)) begin
      frame_mem[pop_addr] <= pop_cmd.pixel;
    end
    if (pop) begin
      rdata <= frame_mem[pop_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (b_en) begin
        b1_valid <= !empty;
      end
      if (out_free) begin
        out_valid <= b1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b1_kind <= pop_cmd.kind;
    end
  end

  always_comb begin
    unique case (b1_kind)
      nnfs_pkg::CMD_WRITE: begin
        result.pixel_out = '0;
        result.status    = nnfs_pkg::ST_WRITE;
      end
      nnfs_pkg::CMD_READ: begin
        result.pixel_out = rdata;
        result.status    = nnfs_pkg::ST_READ;
      end
      default: begin
        result.pixel_out = '0;
        result.status    = nnfs_pkg::ST_RANGE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_free && b1_valid) begin
      out_item <= result;
    end
  end

endmodule

FILE: hdl/nearest_neighbor_frame_scaler_unit.sv
// Top level of the nearest-neighbor frame scaler.
// Depends on nnfs_pkg, nnfs_front, nnfs_queue and nnfs_back.
//
// Channel   Direction  Handshake                     Payload
// -------   ---------  ----------------------------  ------------------------------
// in        sink       in_valid / in_ready           in_item  (mode, pos_x, pos_y, pixel_in)
// out       source     out_valid / out_ready         out_item (pixel_out, status)
// config    sink       write_enable (no wait)        reg_index, write_data
//
// One transaction enters per clock and one result leaves per clock when nothing
// stalls; the single port of the frame memory, one access per cycle, sets that.
// From accept to out_valid a transaction passes front stage 1, which takes the
// transaction at the accepting edge, then front stage 2, the queue, the memory
// read and the result register in that order. Reset clears all valid state and
// restores the register defaults; the frame memory is not cleared. A stall on
// the output backs up through the queue before in_ready drops.
module nearest_neighbor_frame_scaler_unit #(
  parameter int FRAME_PIXELS = 524288,
  parameter int COORD_BITS   = 13,
  parameter int QUEUE_DEPTH  = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              write_enable,
  input  logic [nnfs_pkg::REG_INDEX_W-1:0]  reg_index,
  input  logic [nnfs_pkg::REG_DATA_W-1:0]   write_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  nnfs_pkg::in_item_t                in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output nnfs_pkg::out_item_t               out_item
);

  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  logic              push_valid, queue_full, pop, queue_empty;
  nnfs_pkg::cmd_t    push_cmd, pop_cmd;
  logic [ADDR_W-1:0] push_addr, pop_addr;

  // Scale and classify each transaction, then hand it to the queue.
  nnfs_front #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .COORD_BITS   (COORD_BITS),
    .ADDR_W       (ADDR_W)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_item      (in_item),
    .push_valid   (push_valid),
    .push_cmd     (push_cmd),
    .push_addr    (push_addr),
    .queue_full   (queue_full)
  );

  // Decouple the front pipeline from memory and output stalls.
  nnfs_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_addr  (push_addr),
    .full       (queue_full),
    .pop        (pop),
    .pop_cmd    (pop_cmd),
    .pop_addr   (pop_addr),
    .empty      (queue_empty)
  );

  // Access the frame memory and hold the result until it is taken.
  nnfs_back #(
    .FRAME_PIXELS (FRAME_PIXELS),
    .ADDR_W       (ADDR_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop       (pop),
    .pop_cmd   (pop_cmd),
    .pop_addr  (pop_addr),
    .empty     (queue_empty),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

FILE: sim/nearest_neighbor_frame_scaler_unit_tb.sv
`timescale 1ns / 1ps
// Testbench for nearest_neighbor_frame_scaler_unit: directed and random pixel
// writes and scaled reads across several frame geometries, checked in order
// against a behavioral predictor. Depends on nnfs_pkg and the scaler RTL.
module nearest_neighbor_frame_scaler_unit_tb;
  import nnfs_pkg::*;

  localparam int FRAME_SLOTS = 524288;
  localparam int CLK_HALF    = 4;
  localparam int RUN_LIMIT   = 800000;
  localparam int SETTLE      = 8;     // pipeline is five deep; leave margin

  typedef longint unsigned wide_t;

  // Scoreboard: mirrors the frame store and the six registers, turns every
  // accepted transaction into one expected result and checks results in order.
  class scaler_scoreboard;
    logic [PIXEL_W-1:0] frame[int unsigned];
    logic [SIZE_W-1:0]  src_w, src_h, dst_w, dst_h;
    logic [RATIO_W-1:0] step_x, step_y;
    out_item_t          pending[$];
    int                 errors;

    function new();
      src_w  = SOURCE_WIDTH_RESET;
      src_h  = SOURCE_HEIGHT_RESET;
      dst_w  = DEST_WIDTH_RESET;
      dst_h  = DEST_HEIGHT_RESET;
      step_x = RATIO_X_RESET;
      step_y = RATIO_Y_RESET;
      errors = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [REG_DATA_W-1:0] value);
      case (idx)
        REG_SOURCE_WIDTH:  src_w  = value[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: src_h  = value[SIZE_W-1:0];
        REG_DEST_WIDTH:    dst_w  = value[SIZE_W-1:0];
        REG_DEST_HEIGHT:   dst_h  = value[SIZE_W-1:0];
        REG_RATIO_X:       step_x = value[RATIO_W-1:0];
        REG_RATIO_Y:       step_y = value[RATIO_W-1:0];
        default: ;
      endcase
    endfunction

    // Row-major slot of a source point, if it lies in the frame and the store.
    function bit source_slot(wide_t x, wide_t y, output int unsigned slot);
      wide_t idx;
      slot = 0;
      if (x >= src_w || y >= src_h) return 1'b0;
      idx = y * src_w + x;
      if (idx >= FRAME_SLOTS) return 1'b0;
      slot = idx[31:0];
      return 1'b1;
    endfunction

    // Map a destination pixel onto the source grid; 1 when memory is touched.
    function bit map_read(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                          output wide_t mx, output wide_t my,
                          output int unsigned slot);
      mx = (wide_t'(x) * step_x) >> FRAC_W;
      my = (wide_t'(y) * step_y) >> FRAC_W;
      slot = 0;
      if (x >= dst_w || y >= dst_h) return 1'b0;
      return source_slot(mx, my, slot);
    endfunction

    function void note_input(in_item_t item);
      out_item_t   want;
      int unsigned slot;
      wide_t       mx, my;
      want.pixel_out = '0;
      want.status    = ST_RANGE;
      if (item.mode == MODE_WRITE) begin
        if (source_slot(wide_t'(item.pos_x), wide_t'(item.pos_y), slot)) begin
          frame[slot] = item.pixel_in;
          want.status = ST_WRITE;
        end
      end else if (map_read(item.pos_x, item.pos_y, mx, my, slot)) begin
        want.pixel_out = frame.exists(slot) ? frame[slot] : '0;
        want.status    = ST_READ;
      end
      pending.push_back(want);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual pixel %h status %0d",
                 $time, got.pixel_out, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.pixel_out !== want.pixel_out) begin
        $display("%0t: pixel_out mismatch, expected %h actual %h",
                 $time, want.pixel_out, got.pixel_out);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   write_enable = 1'b0;
  logic [REG_INDEX_W-1:0] reg_index = '0;
  logic [REG_DATA_W-1:0]  write_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  in_item_t               in_item = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;

  scaler_scoreboard sb = new();

  // Long receiver hold-off requested by the stimulus; the sink clears it.
  int hold_req = 0;
  int cycles   = 0;

  // Burst state for random pacing: stretches of zero gaps alternate with
  // stretches of random gaps on both sides.
  int send_calm_left = 0;
  bit send_calm      = 1'b0;
  int recv_calm_left = 0;
  bit recv_calm      = 1'b0;

  nearest_neighbor_frame_scaler_unit #(
    .FRAME_PIXELS(FRAME_SLOTS),
    .COORD_BITS  (POS_W)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .write_enable(write_enable),
    .reg_index   (reg_index),
    .write_data  (write_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog: end the run if it hangs.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [RATIO_W-1:0] step_of(int src, int dst);
    return RATIO_W'((wide_t'(src) << FRAC_W) / wide_t'(dst));
  endfunction

  // Offer one transaction after a random gap. Keep in_valid high across
  // back-to-back transactions; drop it only when a gap follows.
  task automatic send_item(in_item_t item);
    int gap;
    if (send_calm_left == 0) begin
      send_calm      = ($urandom_range(0, 3) == 0);
      send_calm_left = $urandom_range(20, 60);
    end
    send_calm_left--;
    gap = send_calm ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= item;
    do @(posedge clk); while (!in_ready);
    sb.note_input(item);
  endtask

  task automatic write_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                             logic [PIXEL_W-1:0] px);
    in_item_t item;
    item.mode     = MODE_WRITE;
    item.pos_x    = x;
    item.pos_y    = y;
    item.pixel_in = px;
    send_item(item);
  endtask

  // Scaled read. When the mapped source pixel has never been written, load
  // it first so no read ever lands on an undefined frame entry.
  task automatic read_pixel(logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                            logic [PIXEL_W-1:0] junk);
    in_item_t    item;
    wide_t       mx, my;
    int unsigned slot;
    if (sb.map_read(x, y, mx, my, slot) && !sb.frame.exists(slot))
      write_pixel(mx[POS_W-1:0], my[POS_W-1:0], PIXEL_W'($urandom()));
    item.mode     = MODE_READ;
    item.pos_x    = x;
    item.pos_y    = y;
    item.pixel_in = junk;
    send_item(item);
  endtask

  // Drop in_valid and wait until every expected result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(reg_index_t idx, logic [REG_DATA_W-1:0] value);
    write_enable <= 1'b1;
    reg_index    <= idx;
    write_data   <= value;
    @(posedge clk);
    sb.set_reg(idx, value);
  endtask

  // Reprogram all six registers back to back while the pipeline is empty.
  task automatic configure(logic [REG_DATA_W-1:0] sw, logic [REG_DATA_W-1:0] sh,
                           logic [REG_DATA_W-1:0] dw, logic [REG_DATA_W-1:0] dh,
                           logic [REG_DATA_W-1:0] rx, logic [REG_DATA_W-1:0] ry);
    wait_idle();
    put_reg(REG_SOURCE_WIDTH, sw);
    put_reg(REG_SOURCE_HEIGHT, sh);
    put_reg(REG_DEST_WIDTH, dw);
    put_reg(REG_DEST_HEIGHT, dh);
    put_reg(REG_RATIO_X, rx);
    put_reg(REG_RATIO_Y, ry);
    write_enable <= 1'b0;
  endtask

  // One random step: mostly in-range writes and reads, plus edge cases just
  // past the frame sizes and raw noise over the full field ranges.
  task automatic random_traffic();
    int               pick;
    logic [POS_W-1:0] x, y;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      x = POS_W'((sb.src_w != 0) ? $urandom_range(0, sb.src_w - 1) : $urandom_range(0, 8191));
      y = POS_W'((sb.src_h != 0) ? $urandom_range(0, sb.src_h - 1) : $urandom_range(0, 8191));
      write_pixel(x, y, PIXEL_W'($urandom()));
    end else if (pick < 75) begin
      x = POS_W'((sb.dst_w != 0) ? $urandom_range(0, sb.dst_w - 1) : $urandom_range(0, 8191));
      y = POS_W'((sb.dst_h != 0) ? $urandom_range(0, sb.dst_h - 1) : $urandom_range(0, 8191));
      read_pixel(x, y, PIXEL_W'($urandom()));
    end else if (pick < 80) begin
      x = POS_W'(sb.src_w + $urandom_range(0, 2));
      y = POS_W'($urandom_range(0, 1) ? sb.src_h + $urandom_range(0, 2)
                                      : $urandom_range(0, 15));
      write_pixel(x, y, PIXEL_W'($urandom()));
    end else if (pick < 85) begin
      x = POS_W'($urandom_range(0, 1) ? sb.dst_w + $urandom_range(0, 2)
                                      : $urandom_range(0, 15));
      y = POS_W'(sb.dst_h + $urandom_range(0, 2));
      read_pixel(x, y, PIXEL_W'($urandom()));
    end else begin
      x = POS_W'($urandom_range(0, 8191));
      y = POS_W'($urandom_range(0, 8191));
      if ($urandom_range(0, 1)) write_pixel(x, y, PIXEL_W'($urandom()));
      else read_pixel(x, y, PIXEL_W'($urandom()));
    end
  endtask

  task automatic run_random(int n);
    repeat (n) random_traffic();
  endtask

  // Result sink: stall for a random number of cycles before each transaction,
  // or for a long stretch when the stimulus asks, so the pipeline backs up
  // into in_ready.
  initial begin : sink
    int gap;
    int hold;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req > 0) begin
        hold     = hold_req;
        hold_req = 0;
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end else begin
        if (recv_calm_left == 0) begin
          recv_calm      = ($urandom_range(0, 3) == 0);
          recv_calm_left = $urandom_range(20, 60);
        end
        recv_calm_left--;
        gap = recv_calm ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_item);
    end
  end

  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset geometry: 640x480 upscaled to 1920x1080. Hit the frame corners,
    // both pixel extremes, and coordinates just past every size.
    write_pixel(0, 0, 24'hFFFFFF);
    write_pixel(639, 479, 24'h000000);
    write_pixel(1, 0, 24'hA5A5A5);
    write_pixel(640, 0, 24'h5A5A5A);
    write_pixel(0, 480, 24'h123456);
    write_pixel(8191, 8191, 24'hFEDCBA);
    read_pixel(0, 0, 24'h000000);
    read_pixel(1919, 1079, 24'hFFFFFF);
    read_pixel(3, 0, 24'h000000);
    read_pixel(4, 0, 24'h000000);
    read_pixel(1920, 0, 24'h000000);
    read_pixel(0, 1080, 24'h000000);
    read_pixel(8191, 8191, 24'hFFFFFF);
    run_random(220);

    // Tiny frame: reads mostly land on written pixels. Hold the sink off for
    // a long stretch so the input stalls.
    configure(4, 3, 8, 6, step_of(4, 8), step_of(3, 6));
    hold_req = 300;
    run_random(250);

    configure(37, 23, 100, 61, step_of(37, 100), step_of(23, 61));
    run_random(200);

    // Downscale: ratios above one.
    configure(200, 150, 17, 13, step_of(200, 17), step_of(150, 13));
    hold_req = 150;
    run_random(180);

    // Large sizes with extreme ratios: the store is too small for deep
    // rows, a horizontal step of 4096 maps past the source, a zero
    // vertical step collapses every row onto row zero.
    configure(4096, 4096, 8191, 8191, 29'h1000_0000, 29'h0);
    write_pixel(4095, 127, 24'h800001);
    write_pixel(0, 128, 24'h7FFFFE);
    write_pixel(0, 0, 24'h00FF00);
    read_pixel(0, 8190, 24'h000000);
    read_pixel(1, 0, 24'h000000);
    read_pixel(8190, 8190, 24'h000000);
    read_pixel(8191, 0, 24'h000000);

    configure(4096, 4096, 8191, 8191, step_of(4096, 8191), step_of(4096, 8191));
    run_random(150);

    configure(1, 1, 1, 1, step_of(1, 1), step_of(1, 1));
    run_random(60);

    // Oversized ratios: mapped points fall outside the source.
    configure(64, 32, 128, 64, REG_DATA_W'(step_of(64, 128) * 3), 29'h0FFF_FFFF);
    run_random(100);

    // Zero source width, written with junk above the size field.
    configure(29'h1FFF_E000, 16, 16, 16, step_of(16, 16), step_of(16, 16));
    write_pixel(0, 0, 24'h010203);
    read_pixel(0, 0, 24'h000000);
    run_random(40);

    // Zero destination size: every read is out of range.
    configure(16, 16, 29'h1FFF_E000, 29'h1FFF_E000, step_of(16, 16), step_of(16, 16));
    run_random(40);

    configure(640, 480, 1280, 720, REG_DATA_W'($urandom_range(20000, 40000)),
              REG_DATA_W'($urandom_range(20000, 40000)));
    run_random(200);

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
